### rtl/huf_pkg.sv
// ----------------------------------------------------------------------------
// huf_pkg - shared types and constants of the Huffman tree builder
// Node record layout and field widths used by the cell row and the top level.
// ----------------------------------------------------------------------------
package huf_pkg;

    localparam int SYM_W      = 8;
    localparam int LEAF_W     = 14;
    localparam int WT_W       = 19;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 6;
    localparam int MAX_LEAVES = 32;

    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 56;

    // one node of the tree table
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic [WT_W-1:0]  wt;
        logic [IDX_W-1:0] par;
        logic [IDX_W-1:0] lft;
        logic [IDX_W-1:0] rgt;
    } node_t;

endpackage

### rtl/huf_cell.sv
// ----------------------------------------------------------------------------
// huf_cell - one node cell of the rotating node row
// Holds one node; takes a leaf on load, else takes its neighbor's node on shift.
// ----------------------------------------------------------------------------
module huf_cell (
    input  logic          clk,
    input  logic          load_en,
    input  huf_pkg::node_t load_node,
    input  logic          shift_en,
    input  huf_pkg::node_t next_node,
    output huf_pkg::node_t node
);
    import huf_pkg::*;

    node_t node_reg;
    node_t node_next;

    // select load, shift or hold
    always_comb
    begin
        node_next = node_reg;
        if (load_en)
        begin
            node_next = load_node;
        end
        else if (shift_en)
        begin
            node_next = next_node;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
    end

    assign node = node_reg;

endmodule

### rtl/huffman_tree_builder_top.sv
// ----------------------------------------------------------------------------
// huffman_tree_builder_top - Huffman tree builder on a rotating row of node cells
// Loads leaves, builds the tree by full rotations of the row, emits all nodes or an error beat.
// ----------------------------------------------------------------------------
// channel   dir  beat contents
// s_axis    in   one leaf: tdata = symbol, weight; tlast = final leaf
// m_axis    out  one node: tdata = node fields; tuser = error; tlast = run end
//
// The row holds N = 2*MAX_LEAVES-1 cells and rotates one cell per cycle while
// merging, or while emitting when the output is not held; each merge is one
// full rotation, so a run of n leaves takes n-1 rotations of building plus one
// rotation to emit the 2n-1 nodes. The emit rotation holds while the output
// register is full and not taken. Reset clears control state; the cells hold
// no reset value and are written before they are read.
// ----------------------------------------------------------------------------
module huffman_tree_builder_top #(
    parameter int MAX_LEAVES = huf_pkg::MAX_LEAVES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] symbol, [21:8] weight, [23:22] zero
    input  logic [huf_pkg::S_DATA_W-1:0]  s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [5:0] node_index, [13:6] node_symbol, [32:14] node_weight,
    // [38:33] parent_index, [44:39] left_index, [50:45] right_index, [55:51] zero
    output logic [huf_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // [0] error
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast
);
    import huf_pkg::*;

    localparam int N     = 2 * MAX_LEAVES - 1;
    localparam int POS_W = $clog2(N);
    localparam logic [WT_W:0] W_INIT = {1'b1, {WT_W{1'b0}}};

    typedef enum logic [1:0] {ST_IDLE, ST_MERGE, ST_EMIT, ST_ERR} state_t;

    state_t             state_reg;
    logic [POS_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   leaf_count_reg;
    logic [IDX_W-1:0]   k_reg;
    logic [IDX_W-1:0]   top_reg;
    logic               pend_on_reg;
    logic [IDX_W-1:0]   pend_a_reg, pend_b_reg, pend_k_reg;
    logic [WT_W-1:0]    pend_w_reg;
    logic [IDX_W-1:0]   m1i_reg, m2i_reg;
    logic [WT_W:0]      m1w_reg, m2w_reg;
    logic               ov_reg;
    logic [M_DATA_W-1:0] od_reg;
    logic               ou_reg;
    logic               ol_reg;

    node_t              cells [N];
    node_t              head_u;
    node_t              leaf_node;
    logic [N-1:0]       load_en;
    logic               shift_en;
    logic               acc;
    logic               room;
    logic [IDX_W-1:0]   idx;
    logic               cand;
    logic               slot_free;
    logic               out_load;
    logic [IDX_W-1:0]   m1i_next, m2i_next;
    logic [WT_W:0]      m1w_next, m2w_next;
    logic [CNT_W-1:0]   nc;
    logic [WT_W:0]      sum;

    // input handshake and leaf write
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign room          = (leaf_count_reg < CNT_W'(MAX_LEAVES));
    assign nc            = room ? leaf_count_reg + CNT_W'(1) : leaf_count_reg;
    assign slot_free     = !ov_reg || m_axis_tready;

    // output register takes a new beat this cycle
    assign out_load = slot_free && ((state_reg == ST_ERR) ||
                                    ((state_reg == ST_EMIT) && (idx <= top_reg)));

    always_comb
    begin
        leaf_node.sym = s_axis_tdata[SYM_W-1:0];
        leaf_node.wt  = WT_W'(s_axis_tdata[SYM_W+LEAF_W-1:SYM_W]);
        leaf_node.par = '0;
        leaf_node.lft = '0;
        leaf_node.rgt = '0;
    end

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            load_en[i] = acc && room && (leaf_count_reg == CNT_W'(i));
        end
    end

    assign shift_en = (state_reg == ST_MERGE) || ((state_reg == ST_EMIT) && slot_free);

    // head node with the previous merge applied
    assign idx = IDX_W'(cnt_reg) + IDX_W'(1);

    always_comb
    begin
        head_u = cells[0];
        if (pend_on_reg)
        begin
            if (idx == pend_a_reg || idx == pend_b_reg)
            begin
                head_u.par = pend_k_reg;
            end
            if (idx == pend_k_reg)
            begin
                head_u.sym = '0;
                head_u.wt  = pend_w_reg;
                head_u.par = '0;
                head_u.lft = pend_a_reg;
                head_u.rgt = pend_b_reg;
            end
        end
    end

    // cell row, the last cell takes the updated head
    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            huf_cell u_cell (
                .clk       (clk),
                .load_en   (load_en[g]),
                .load_node (leaf_node),
                .shift_en  (shift_en),
                .next_node ((g == N - 1) ? head_u : cells[(g + 1) % N]),
                .node      (cells[g])
            );
        end
    endgenerate

    // running two-minimum tracker, strict compare keeps lowest index on ties
    assign cand = (state_reg == ST_MERGE) && (idx < k_reg) && (head_u.par == '0);

    always_comb
    begin
        m1i_next = m1i_reg;
        m1w_next = m1w_reg;
        m2i_next = m2i_reg;
        m2w_next = m2w_reg;
        if (cand)
        begin
            if ({1'b0, head_u.wt} < m1w_reg)
            begin
                m2i_next = m1i_reg;
                m2w_next = m1w_reg;
                m1i_next = idx;
                m1w_next = {1'b0, head_u.wt};
            end
            else if ({1'b0, head_u.wt} < m2w_reg)
            begin
                m2i_next = idx;
                m2w_next = {1'b0, head_u.wt};
            end
        end
    end

    assign sum = m1w_next + m2w_next;

    // control state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            leaf_count_reg <= '0;
            k_reg          <= '0;
            top_reg        <= '0;
            pend_on_reg    <= 1'b0;
            pend_a_reg     <= '0;
            pend_b_reg     <= '0;
            pend_k_reg     <= '0;
            pend_w_reg     <= '0;
            m1i_reg        <= '0;
            m2i_reg        <= '0;
            m1w_reg        <= W_INIT;
            m2w_reg        <= W_INIT;
            ov_reg         <= 1'b0;
            od_reg         <= '0;
            ou_reg         <= 1'b0;
            ol_reg         <= 1'b0;
        end
        else
        begin
            if (m_axis_tready && !out_load)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (acc)
                    begin
                        if (s_axis_tlast)
                        begin
                            leaf_count_reg <= '0;
                            if (nc < CNT_W'(2))
                            begin
                                state_reg <= ST_ERR;
                            end
                            else
                            begin
                                top_reg     <= IDX_W'({1'b0, nc, 1'b0} - 8'd1);
                                k_reg       <= IDX_W'(nc) + IDX_W'(1);
                                cnt_reg     <= '0;
                                pend_on_reg <= 1'b0;
                                m1w_reg     <= W_INIT;
                                m2w_reg     <= W_INIT;
                                state_reg   <= ST_MERGE;
                            end
                        end
                        else
                        begin
                            leaf_count_reg <= nc;
                        end
                    end
                end
                ST_ERR:
                begin
                    if (slot_free)
                    begin
                        ov_reg    <= 1'b1;
                        od_reg    <= '0;
                        ou_reg    <= 1'b1;
                        ol_reg    <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_MERGE:
                begin
                    if (cnt_reg == POS_W'(N - 1))
                    begin
                        pend_on_reg <= 1'b1;
                        pend_a_reg  <= m1i_next;
                        pend_b_reg  <= m2i_next;
                        pend_k_reg  <= k_reg;
                        pend_w_reg  <= sum[WT_W-1:0];
                        m1w_reg     <= W_INIT;
                        m2w_reg     <= W_INIT;
                        cnt_reg     <= '0;
                        if (k_reg == top_reg)
                        begin
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            k_reg <= k_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        m1i_reg <= m1i_next;
                        m1w_reg <= m1w_next;
                        m2i_reg <= m2i_next;
                        m2w_reg <= m2w_next;
                        cnt_reg <= cnt_reg + POS_W'(1);
                    end
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        if (idx <= top_reg)
                        begin
                            ov_reg <= 1'b1;
                            od_reg <= M_DATA_W'({head_u.rgt, head_u.lft, head_u.par,
                                                 head_u.wt, head_u.sym, idx});
                            ou_reg <= 1'b0;
                            ol_reg <= (idx == top_reg);
                        end
                        if (cnt_reg == POS_W'(N - 1))
                        begin
                            cnt_reg     <= '0;
                            pend_on_reg <= 1'b0;
                            state_reg   <= ST_IDLE;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + POS_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;
    assign m_axis_tlast  = ol_reg;

endmodule

### rtl/huf_checker.sv
// ----------------------------------------------------------------------------
// huf_checker - port-level checks of the Huffman tree builder
// Watches the output channel of the top level; attached by bind.
// ----------------------------------------------------------------------------
module huf_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [huf_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic                         m_axis_tuser,
    input logic                         m_axis_tlast
);
    import huf_pkg::*;

    // a stalled beat stays
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    // an error beat ends its run
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("error beat without tlast");

    // an error beat carries no node
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("error beat with nonzero data");

    // a node beat names a real node
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[IDX_W-1:0] != '0)
        else $error("node beat with index zero");

endmodule

bind huffman_tree_builder_top huf_checker u_huf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### dv/huffman_tree_builder_top_tb.sv
// ----------------------------------------------------------------------------
// huffman_tree_builder_top_tb - self-checking bench for the Huffman tree builder
// Streams sets of leaves into the block, rebuilds each tree alongside it and
// compares every emitted node beat field by field, under varied back-pressure.
// ----------------------------------------------------------------------------
module huffman_tree_builder_top_tb;

    import huf_pkg::*;

    localparam int TBL        = 64;
    localparam int SRC_PCT    = 58;
    localparam int SINK_PCT   = 58;
    localparam int BOTH_PCT   = 22;
    localparam int DRAIN_CYC  = 200;

    // one node beat as it leaves the block
    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [SYM_W-1:0] sym;
        logic [WT_W-1:0]  wt;
        logic [IDX_W-1:0] par;
        logic [IDX_W-1:0] lft;
        logic [IDX_W-1:0] rgt;
        logic             err;
        logic             last;
    } node_beat_t;

    // tree rebuild and expected node beats
    class tree_scoreboard;
        logic [SYM_W-1:0] sym_tab [TBL];
        logic [WT_W-1:0]  wt_tab  [TBL];
        logic [IDX_W-1:0] par_tab [TBL];
        logic [IDX_W-1:0] lft_tab [TBL];
        logic [IDX_W-1:0] rgt_tab [TBL];
        int               held;
        node_beat_t       node_q [$];
        int               errors;
        int               nodes_seen;
        int               runs;
        int               err_runs;

        function new();
            held = 0;
            errors = 0;
            nodes_seen = 0;
            runs = 0;
            err_runs = 0;
        endfunction

        task report(input string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        // lightest parentless node in 1..upto, lowest index on ties
        function int lightest(input int upto, input int skip);
            int best;
            int bw;
            best = 0;
            bw = 1 << 20;
            for (int k = 1; k <= upto && k < TBL; k++)
                if (par_tab[k] == 0 && k != skip && int'(wt_tab[k]) < bw)
                begin
                    bw = wt_tab[k];
                    best = k;
                end
            return best;
        endfunction

        function void note_leaf(input logic [SYM_W-1:0] s, input logic [LEAF_W-1:0] w,
                                input logic l);
            int n;
            int top;
            int a;
            int b;
            node_beat_t nb;
            if (held < MAX_LEAVES)
            begin
                held++;
                sym_tab[held] = s;
                wt_tab[held]  = WT_W'(w);
                par_tab[held] = '0;
                lft_tab[held] = '0;
                rgt_tab[held] = '0;
            end
            if (!l)
                return;
            n = held;
            held = 0;
            runs++;
            if (n < 2)
            begin
                nb = '{idx: '0, sym: '0, wt: '0, par: '0, lft: '0, rgt: '0,
                       err: 1'b1, last: 1'b1};
                node_q.push_back(nb);
                err_runs++;
                return;
            end
            top = 2 * n - 1;
            // merge the two lightest parentless nodes into each new node
            for (int k = n + 1; k <= top; k++)
            begin
                a = lightest(k - 1, 0);
                b = lightest(k - 1, a);
                par_tab[a] = IDX_W'(k);
                par_tab[b] = IDX_W'(k);
                sym_tab[k] = '0;
                par_tab[k] = '0;
                lft_tab[k] = IDX_W'(a);
                rgt_tab[k] = IDX_W'(b);
                wt_tab[k]  = wt_tab[a] + wt_tab[b];
            end
            for (int k = 1; k <= top; k++)
            begin
                nb = '{idx: IDX_W'(k), sym: sym_tab[k], wt: wt_tab[k], par: par_tab[k],
                       lft: lft_tab[k], rgt: rgt_tab[k], err: 1'b0, last: (k == top)};
                node_q.push_back(nb);
            end
        endfunction

        task check_node(input node_beat_t got);
            node_beat_t x;
            nodes_seen++;
            if (node_q.size() == 0)
            begin
                report($sformatf("unexpected beat idx=%0d", got.idx));
                return;
            end
            x = node_q.pop_front();
            if (got.idx !== x.idx)
                report($sformatf("node_index got %0d exp %0d", got.idx, x.idx));
            if (got.sym !== x.sym)
                report($sformatf("node %0d symbol got %0d exp %0d", x.idx, got.sym, x.sym));
            if (got.wt !== x.wt)
                report($sformatf("node %0d weight got %0d exp %0d", x.idx, got.wt, x.wt));
            if (got.par !== x.par)
                report($sformatf("node %0d parent got %0d exp %0d", x.idx, got.par, x.par));
            if (got.lft !== x.lft)
                report($sformatf("node %0d left got %0d exp %0d", x.idx, got.lft, x.lft));
            if (got.rgt !== x.rgt)
                report($sformatf("node %0d right got %0d exp %0d", x.idx, got.rgt, x.rgt));
            if (got.err !== x.err)
                report($sformatf("node %0d error got %0b exp %0b", x.idx, got.err, x.err));
            if (got.last !== x.last)
                report($sformatf("node %0d last got %0b exp %0b", x.idx, got.last, x.last));
        endtask

        function int pending();
            return node_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    tree_scoreboard sb = new();
    logic src_idle;
    logic sink_stall;
    int   src_pct;
    int   sink_pct;
    int   leaves_sent;

    huffman_tree_builder_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // random receiver back-pressure
    always @(negedge clk)
        m_axis_tready <= !(sink_stall && $urandom_range(99) < sink_pct);

    // capture accepted node beats
    always @(posedge clk)
    begin
        node_beat_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.idx  = m_axis_tdata[5:0];
            got.sym  = m_axis_tdata[13:6];
            got.wt   = m_axis_tdata[32:14];
            got.par  = m_axis_tdata[38:33];
            got.lft  = m_axis_tdata[44:39];
            got.rgt  = m_axis_tdata[50:45];
            got.err  = m_axis_tuser;
            got.last = m_axis_tlast;
            sb.check_node(got);
        end
    end

    // one leaf beat, called and returning at a falling edge
    task automatic send_leaf(input logic [SYM_W-1:0] s, input logic [LEAF_W-1:0] w,
                             input logic l);
        while (src_idle && $urandom_range(99) < src_pct)
            @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {2'b00, w, s};
        s_axis_tlast  = l;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_leaf(s, w, l);
        leaves_sent++;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    function automatic logic [LEAF_W-1:0] pick_weight();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return LEAF_W'($urandom_range(3));
        else if (r < 90)
            return LEAF_W'($urandom_range(9999));
        else
            return LEAF_W'($urandom_range(16383));
    endfunction

    // one set of leaves with random content
    task automatic send_run(input int len);
        for (int i = 0; i < len; i++)
            send_leaf(SYM_W'($urandom_range(255)), pick_weight(), i == len - 1);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 1;
        else if (r < 70)
            return $urandom_range(8, 2);
        else if (r < 93)
            return $urandom_range(32, 9);
        else
            return $urandom_range(36, 33);
    endfunction

    initial
    begin
        int phase_budget;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b1;
        src_idle = 1'b0;
        sink_stall = 1'b0;
        src_pct = SRC_PCT;
        sink_pct = SINK_PCT;
        leaves_sent = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: lone leaf gives the error beat
        send_leaf(8'd65, 14'd5, 1'b1);
        // extremes of symbol and weight
        send_leaf(8'd0, 14'd0, 1'b0);
        send_leaf(8'd255, 14'd9999, 1'b1);
        send_leaf(8'hAA, 14'h3FFF, 1'b0);
        send_leaf(8'h55, 14'h2AAA, 1'b1);
        // equal weights exercise the lowest-index tie rule
        for (int i = 0; i < 4; i++)
            send_leaf(SYM_W'(i + 1), 14'd7, i == 3);
        // all zero weights
        for (int i = 0; i < 3; i++)
            send_leaf(SYM_W'(i + 100), 14'd0, i == 2);
        // ascending and descending weights
        for (int i = 0; i < 5; i++)
            send_leaf(SYM_W'(i + 10), LEAF_W'(i * 1000), i == 4);
        for (int i = 0; i < 5; i++)
            send_leaf(SYM_W'(i + 20), LEAF_W'(9999 - i * 2000), i == 4);

        // random sets across the four idling modes
        phase_budget = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            while (sb.pending() != 0)
                @(posedge clk);
            @(negedge clk);
            src_idle   = (ph == 1 || ph == 3);
            sink_stall = (ph == 2 || ph == 3);
            src_pct    = (ph == 3) ? BOTH_PCT : SRC_PCT;
            sink_pct   = (ph == 3) ? BOTH_PCT : SINK_PCT;
            if (ph == 3)
            begin
                // overfilled table: extra leaves are dropped
                send_run(36);
            end
            phase_budget += 75;
            while (leaves_sent < 10 + phase_budget)
                send_run(pick_len());
        end
        src_idle = 1'b0;
        sink_stall = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d node beats never arrived", sb.pending()));
        $display("Sent %0d leaves in %0d sets (%0d too short), checked %0d node beats.",
                 leaves_sent, sb.runs, sb.err_runs, sb.nodes_seen);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial
    begin
        #8000000;
        $display("Timeout with %0d node beats outstanding", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
